>>> rtl/phm_pkg.sv
// Shared types and constants of the pseudocolor heat map pixel mapper.
// No dependencies; every other file of the block imports this package.
package phm_pkg;

   // default sample width and fixed scale of the color ramp
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int SCALE_TOP       = 765;
   localparam int THIRD           = 255;
   localparam int TWO_THIRDS      = 510;
   localparam int QUOT_BITS       = 10;   // scale position 0..765 fits in 10 bits

   // floor(s/3) for s <= 765 as (s * 683) >> 11
   localparam int GREY_RECIP      = 683;
   localparam int GREY_SHIFT      = 11;
   localparam int GREY_PROD_W     = 20;

   // register indexes of the configuration port
   localparam logic [1:0] REG_COLORMAP = 2'd0;
   localparam logic [1:0] REG_BLACK    = 2'd1;
   localparam logic [1:0] REG_WHITE    = 2'd2;

   // color map codes; the unused code falls back to grey
   localparam logic [1:0] MAP_BLACKBODY = 2'd0;
   localparam logic [1:0] MAP_RAINBOW   = 2'd1;
   localparam logic [1:0] MAP_GREY      = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_LOW,
      STATUS_HIGH,
      STATUS_INVALID
   } status_type;

   // side information that rides along with each item through the chain
   typedef struct packed {
      status_type status;
      logic       frame_done;
   } ctl_type;

endpackage

>>> rtl/phm_intf.sv
// Channel interfaces of the pseudocolor heat map: sample input, pixel output
// and configuration writes. Depends on phm_pkg.
interface phm_req_if import phm_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          frame_end;

   modport source (output valid, output sample, output frame_end, input ready);
   modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

interface phm_rsp_if import phm_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   status_type status;
   logic       frame_done;

   modport source (output valid, output red, output green, output blue,
                   output status, output frame_done, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input status, input frame_done, output ready);
endinterface

interface phm_csr_if import phm_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                   valid;
   logic                   ready;
   logic [1:0]             index;
   logic [SAMPLE_BITS-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/pseudocolor_heat_map.sv
// Top level of the pseudocolor heat map pixel mapper: configuration registers,
// front cells, divider cell chain and color cell. Depends on phm_pkg, phm_intf
// and the phm_* modules.
//
// Maps each signed sample to an RGB pixel plus status and frame marker. One
// item is accepted every clock cycle while the output does not stall; each
// item passes in order through two front cells (level compare, scaling by
// 765), ten divider cells that each settle one bit of the scale position,
// and the color cell that also serves as output register. Every cell has its
// own valid bit and stalls only when the cell after it is full, so a stalled
// output fills the bubbles behind it before input ready drops. There is no
// clearing pass after reset. Write the levels and the color map only while
// no item is in flight; the configuration port is always ready.
module pseudocolor_heat_map import phm_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input logic           clock,
   input logic           reset,
   phm_req_if.sink       req_if,
   phm_rsp_if.source     rsp_if,
   phm_csr_if.sink       csr_if
);

   localparam int NUM_W = SAMPLE_BITS + QUOT_BITS;
   localparam logic [SAMPLE_BITS-1:0] WHITE_RESET = (SAMPLE_BITS > 16)
      ? SAMPLE_BITS'(32767) : SAMPLE_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);

   logic [1:0]                    colormap_ff;
   logic signed [SAMPLE_BITS-1:0] black_ff;
   logic signed [SAMPLE_BITS-1:0] white_ff;

   logic                   chain_valid [QUOT_BITS+1];
   logic                   chain_ready [QUOT_BITS+1];
   logic [NUM_W-1:0]       chain_rem   [QUOT_BITS+1];
   logic [SAMPLE_BITS-1:0] chain_den   [QUOT_BITS+1];
   logic [QUOT_BITS-1:0]   chain_quot  [QUOT_BITS+1];
   ctl_type                chain_ctl   [QUOT_BITS+1];
   ctl_type                rsp_ctl;

   // configuration registers
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         colormap_ff <= MAP_BLACKBODY;
         black_ff    <= '0;
         white_ff    <= WHITE_RESET;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            REG_COLORMAP: colormap_ff <= csr_if.data[1:0];
            REG_BLACK:    black_ff    <= csr_if.data;
            REG_WHITE:    white_ff    <= csr_if.data;
            default:      ;
         endcase
      end
   end

   // front cells
   phm_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_if.valid),
      .in_ready     (req_if.ready),
      .in_sample    (req_if.sample),
      .in_frame_end (req_if.frame_end),
      .black_level  (black_ff),
      .white_level  (white_ff),
      .out_valid    (chain_valid[0]),
      .out_ready    (chain_ready[0]),
      .out_rem      (chain_rem[0]),
      .out_den      (chain_den[0]),
      .out_ctl      (chain_ctl[0])
   );

   assign chain_quot[0] = '0;

   // divider chain, most significant quotient bit first
   for (genvar k = 0; k < QUOT_BITS; k++) begin : g_div
      phm_div_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .BIT         (QUOT_BITS - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_rem    (chain_rem[k]),
         .in_den    (chain_den[k]),
         .in_quot   (chain_quot[k]),
         .in_ctl    (chain_ctl[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_rem   (chain_rem[k+1]),
         .out_den   (chain_den[k+1]),
         .out_quot  (chain_quot[k+1]),
         .out_ctl   (chain_ctl[k+1])
      );
   end

   // color cell and output register
   phm_color u_color (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[QUOT_BITS]),
      .in_ready  (chain_ready[QUOT_BITS]),
      .in_quot   (chain_quot[QUOT_BITS]),
      .in_ctl    (chain_ctl[QUOT_BITS]),
      .colormap  (colormap_ff),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_red   (rsp_if.red),
      .out_green (rsp_if.green),
      .out_blue  (rsp_if.blue),
      .out_ctl   (rsp_ctl)
   );

   assign rsp_if.status     = rsp_ctl.status;
   assign rsp_if.frame_done = rsp_ctl.frame_done;

endmodule

>>> rtl/phm_front.sv
// Front cells: level compare, offset and scaling of the sample by 765.
// Two registered stages; depends on phm_pkg.
module phm_front import phm_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int NUM_W      = SAMPLE_BITS + QUOT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [SAMPLE_BITS-1:0] in_sample,
   input  logic                          in_frame_end,
   input  logic signed [SAMPLE_BITS-1:0] black_level,
   input  logic signed [SAMPLE_BITS-1:0] white_level,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [NUM_W-1:0]              out_rem,
   output logic [SAMPLE_BITS-1:0]        out_den,
   output ctl_type                       out_ctl
);

   logic                        s1_valid_ff, s1_valid_in, s1_ready;
   logic [SAMPLE_BITS-1:0]      s1_diff_ff, s1_diff_in;
   logic [SAMPLE_BITS-1:0]      s1_den_ff, s1_den_in;
   ctl_type                     s1_ctl_ff, s1_ctl_in;
   logic                        s2_valid_ff, s2_valid_in, s2_ready;
   logic [NUM_W-1:0]            s2_num_ff, s2_num_in;
   logic [SAMPLE_BITS-1:0]      s2_den_ff;
   ctl_type                     s2_ctl_ff;
   logic signed [SAMPLE_BITS:0] diff_wide, den_wide;

   // stage 1: classify the sample against the levels
   always_comb begin
      diff_wide = {in_sample[SAMPLE_BITS-1], in_sample}
                - {black_level[SAMPLE_BITS-1], black_level};
      den_wide  = {white_level[SAMPLE_BITS-1], white_level}
                - {black_level[SAMPLE_BITS-1], black_level};
      s1_ctl_in.frame_done = in_frame_end;
      s1_diff_in           = '0;
      s1_den_in            = den_wide[SAMPLE_BITS-1:0];
      if (white_level <= black_level) begin
         s1_ctl_in.status = STATUS_INVALID;
      end else if (in_sample < black_level) begin
         s1_ctl_in.status = STATUS_LOW;
      end else if (in_sample > white_level) begin
         s1_ctl_in.status = STATUS_HIGH;
      end else begin
         s1_ctl_in.status = STATUS_OK;
         s1_diff_in       = diff_wide[SAMPLE_BITS-1:0];
      end
   end

   // stage 2: numerator (sample - black) * 765
   assign s2_num_in = NUM_W'(s1_diff_ff) * NUM_W'(SCALE_TOP);

   // handoff between the two stages
   assign s2_ready    = !s2_valid_ff || out_ready;
   assign s1_ready    = !s1_valid_ff || s2_ready;
   assign in_ready    = s1_ready;
   assign s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_diff_ff <= s1_diff_in;
         s1_den_ff  <= s1_den_in;
         s1_ctl_ff  <= s1_ctl_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_num_ff <= s2_num_in;
         s2_den_ff <= s1_den_ff;
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_rem   = s2_num_ff;
   assign out_den   = s2_den_ff;
   assign out_ctl   = s2_ctl_ff;

endmodule

>>> rtl/phm_div_cell.sv
// One cell of the divider chain: resolves one quotient bit by a trial
// subtract of the shifted divisor. Depends on phm_pkg.
module phm_div_cell import phm_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int BIT         = 0,
   localparam int NUM_W      = SAMPLE_BITS + QUOT_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [NUM_W-1:0]       in_rem,
   input  logic [SAMPLE_BITS-1:0] in_den,
   input  logic [QUOT_BITS-1:0]   in_quot,
   input  ctl_type                in_ctl,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [NUM_W-1:0]       out_rem,
   output logic [SAMPLE_BITS-1:0] out_den,
   output logic [QUOT_BITS-1:0]   out_quot,
   output ctl_type                out_ctl
);

   logic                   valid_ff, valid_in;
   logic [NUM_W-1:0]       rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] den_ff;
   logic [QUOT_BITS-1:0]   quot_ff, quot_in;
   ctl_type                ctl_ff;
   logic [NUM_W-1:0]       trial;
   logic                   take;

   // trial subtract of den * 2^BIT
   always_comb begin
      trial        = NUM_W'(in_den) << BIT;
      take         = in_rem >= trial;
      rem_in       = take ? in_rem - trial : in_rem;
      quot_in      = in_quot;
      quot_in[BIT] = take;
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rem_ff  <= rem_in;
         den_ff  <= in_den;
         quot_ff <= quot_in;
         ctl_ff  <= in_ctl;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quot  = quot_ff;
   assign out_ctl   = ctl_ff;

endmodule

>>> rtl/phm_color.sv
// Last cell: turns the scale position into red, green and blue through the
// selected color map and holds the pixel for the output. Depends on phm_pkg.
module phm_color import phm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [QUOT_BITS-1:0] in_quot,
   input  ctl_type              in_ctl,
   input  logic [1:0]           colormap,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [7:0]           out_red,
   output logic [7:0]           out_green,
   output logic [7:0]           out_blue,
   output ctl_type              out_ctl
);

   logic                   valid_ff, valid_in;
   logic [7:0]             red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   ctl_type                ctl_ff;
   logic [QUOT_BITS-1:0]   pos;
   logic [GREY_PROD_W-1:0] grey_prod;
   logic [7:0]             grey;
   logic [7:0]             rise;   // position within the current third
   logic [QUOT_BITS-1:0]   fall_wide;

   // scale position after clamping
   always_comb begin
      case (in_ctl.status)
         STATUS_LOW:  pos = '0;
         STATUS_HIGH: pos = QUOT_BITS'(SCALE_TOP);
         default:     pos = in_quot;
      endcase
   end

   // color maps
   always_comb begin
      grey_prod = GREY_PROD_W'(pos) * GREY_PROD_W'(GREY_RECIP);
      grey      = grey_prod[GREY_SHIFT +: 8];
      if (pos < QUOT_BITS'(THIRD)) begin
         rise = pos[7:0];
      end else if (pos < QUOT_BITS'(TWO_THIRDS)) begin
         rise = 8'(pos - QUOT_BITS'(THIRD));
      end else begin
         rise = 8'(pos - QUOT_BITS'(TWO_THIRDS));
      end
      fall_wide = 10'(~rise);   // 255 - rise
      red_in    = '0;
      green_in  = '0;
      blue_in   = '0;
      if (in_ctl.status != STATUS_INVALID) begin
         case (colormap)
            MAP_BLACKBODY: begin
               if (pos < QUOT_BITS'(THIRD)) begin
                  red_in = rise;
               end else if (pos < QUOT_BITS'(TWO_THIRDS)) begin
                  red_in   = 8'd255;
                  green_in = rise;
               end else begin
                  red_in   = 8'd255;
                  green_in = 8'd255;
                  blue_in  = rise;
               end
            end
            MAP_RAINBOW: begin
               if (pos < QUOT_BITS'(THIRD)) begin
                  green_in = rise;
                  blue_in  = 8'd255;
               end else if (pos < QUOT_BITS'(TWO_THIRDS)) begin
                  red_in   = rise;
                  green_in = 8'd255;
                  blue_in  = fall_wide[7:0];
               end else begin
                  red_in   = 8'd255;
                  green_in = fall_wide[7:0];
               end
            end
            default: begin
               red_in   = grey;
               green_in = grey;
               blue_in  = grey;
            end
         endcase
      end
   end

   // output register
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         ctl_ff   <= in_ctl;
      end
   end

   assign out_valid = valid_ff;
   assign out_red   = red_ff;
   assign out_green = green_ff;
   assign out_blue  = blue_ff;
   assign out_ctl   = ctl_ff;

endmodule

>>> rtl/phm_checker.sv
// Port-level checks of the pseudocolor heat map, bound to the top level.
// Depends on phm_pkg and pseudocolor_heat_map.
module phm_checker import phm_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue,
   input status_type rsp_status,
   input logic       rsp_frame_done
);

   // bad levels always give a black pixel
   a_invalid_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_INVALID
      |-> rsp_red == 8'd0 && rsp_green == 8'd0 && rsp_blue == 8'd0)
      else $error("invalid levels gave a non-black pixel");

   // clamp below sits at the start of every ramp, red off
   a_low_red: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_LOW |-> rsp_red == 8'd0)
      else $error("clamped-low pixel has red set");

   // clamp above sits at the end of every ramp, red full
   a_high_red: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_HIGH |-> rsp_red == 8'd255)
      else $error("clamped-high pixel has red below full");

   // a stalled pixel holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red)
      && $stable(rsp_green) && $stable(rsp_blue) && $stable(rsp_status)
      && $stable(rsp_frame_done))
      else $error("stalled pixel changed");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("pixel valid right after reset");

endmodule

bind pseudocolor_heat_map phm_checker u_phm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_red        (rsp_if.red),
   .rsp_green      (rsp_if.green),
   .rsp_blue       (rsp_if.blue),
   .rsp_status     (rsp_if.status),
   .rsp_frame_done (rsp_if.frame_done)
);
